@@ sv/layer_zorder_manager_core_defines.svh @@
// Assertion macros for the checker file.
`ifndef LAYER_ZORDER_MANAGER_CORE_DEFINES_SVH
`define LAYER_ZORDER_MANAGER_CORE_DEFINES_SVH

// Clocked assertion, held off while reset is asserted
`define LZM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define LZM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/lzm_pkg.sv @@
`default_nettype none
package lzm_pkg;

  // Default sizing
  localparam int unsigned MaxLayersDef = 256;
  localparam int unsigned CoordBitsDef = 14;

  // Operation codes
  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_FREE    = 3'd1;
  localparam logic [2:0] OP_SIZE    = 3'd2;
  localparam logic [2:0] OP_MOVE    = 3'd3;
  localparam logic [2:0] OP_HEIGHT  = 3'd4;
  localparam logic [2:0] OP_REFRESH = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_ACK        = 2'd0;
  localparam logic [1:0] KIND_ALLOC      = 2'd1;
  localparam logic [1:0] KIND_ALLOC_FAIL = 2'd2;
  localparam logic [1:0] KIND_REDRAW     = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         layer;
    logic signed [14:0] x0;
    logic signed [14:0] y0;
    logic signed [14:0] x1;
    logic signed [14:0] y1;
    logic [7:0]         from_height;
  } res_t;

  // Clamp a sum to the 15-bit screen range
  function automatic logic signed [14:0] sat15(input logic signed [17:0] v);
    logic signed [14:0] r;
    if (v < -18'sd16384) r = -15'sd16384;
    else if (v > 18'sd16383) r = 15'sd16383;
    else r = v[14:0];
    return r;
  endfunction

  // Result with no rectangle
  function automatic res_t mk_plain(input logic [1:0] kind, input logic [7:0] layer);
    res_t r;
    r = '0;
    r.kind = kind;
    r.layer = layer;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/lzm_ram.sv @@
`default_nettype none
module lzm_ram #(
  parameter int unsigned DEPTH = lzm_pkg::MaxLayersDef,
  parameter int unsigned WIDTH = 8
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

@@ sv/lzm_rect.sv @@
`default_nettype none
// Shared adder unit: screen rectangle from a layer origin and four offsets
module lzm_rect #(
  parameter int unsigned COORD_BITS = lzm_pkg::CoordBitsDef
) (
  input  wire signed [COORD_BITS-1:0] base_x_i,
  input  wire signed [COORD_BITS-1:0] base_y_i,
  input  wire signed [13:0]           off_x0_i,
  input  wire signed [13:0]           off_y0_i,
  input  wire signed [13:0]           off_x1_i,
  input  wire signed [13:0]           off_y1_i,
  output logic signed [14:0]          x0_o,
  output logic signed [14:0]          y0_o,
  output logic signed [14:0]          x1_o,
  output logic signed [14:0]          y1_o
);

  logic signed [17:0] bx, by;

  // Add offsets and saturate
  always_comb begin
    bx   = 18'(base_x_i);
    by   = 18'(base_y_i);
    x0_o = lzm_pkg::sat15(bx + 18'(off_x0_i));
    y0_o = lzm_pkg::sat15(by + 18'(off_y0_i));
    x1_o = lzm_pkg::sat15(bx + 18'(off_x1_i));
    y1_o = lzm_pkg::sat15(by + 18'(off_y1_i));
  end

endmodule
`default_nettype wire

@@ sv/layer_zorder_manager_core.sv @@
// Layer z-order manager: a pool of display layers and their stacking order.
// Slave channel: one command per transfer; tuser holds the operation code,
// tdata the layer and its arguments. Master channel: one or two results per
// command, tuser the result kind, tlast on the final result of a command.
// Commands run one at a time under a small sequencer; s_axis_tready is high
// only while it is idle. Allocate scans the pool upward from index 0 for
// the first free layer. Set height, and free of a visible layer, shift the
// order table one entry at a time (one order-table read and one write per
// shifted entry); move, resize and refresh need no shift.
// Results leave through an output register; a second result follows in the
// cycle after the first is taken. A stalled receiver holds the sequencer in
// its emit step only; the next command is taken once the last result sits
// in the output register.
// Reset clears the pool, sets the top index to empty and drops any pending
// result. Layer geometry is undefined until written.
`default_nettype none
module layer_zorder_manager_core #(
  parameter int unsigned MAX_LAYERS = lzm_pkg::MaxLayersDef,
  parameter int unsigned COORD_BITS = lzm_pkg::CoordBitsDef
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // layer_id[7:0], new_height[17:8], pos_x[31:18], pos_y[45:32],
  // size_w[57:46], size_h[69:58], box_x0[83:70], box_y0[97:84],
  // box_x1[111:98], box_y1[125:112], zero fill
  input  wire [127:0]  s_axis_tdata,
  // op[2:0]
  input  wire [2:0]    s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // layer_out[7:0], region_x0[22:8], region_y0[37:23], region_x1[52:38],
  // region_y1[67:53], from_height[75:68], zero fill
  output logic [79:0]  m_axis_tdata,
  // kind[1:0]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam int unsigned IDX_W = $clog2(MAX_LAYERS);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_LOAD, S_SH_RD, S_SH_WR, S_PLACE, S_MOVE2, S_EMIT
  } state_e;

  state_e state_q;

  // Control state
  logic [MAX_LAYERS-1:0] used_q;
  logic signed [8:0]     top_q;
  logic signed [8:0]     cur_q, lim_q, ht_q, hold_q;
  logic                  up_q, place_q, lower_q, hide_q;
  logic                  two_q, sel_q, ok_q;
  logic                  m_valid_q, m_last_q;

  // Command payload
  logic [2:0]              op_q;
  logic [7:0]              lid_q;
  logic signed [9:0]       nh_q;
  logic signed [13:0]      px_q, py_q, bx0_q, by0_q, bx1_q, by1_q;
  logic [11:0]             sw_q, sh_q;
  logic signed [COORD_BITS-1:0] gx_q, gy_q;
  logic [11:0]             gw_q, gh_q;
  lzm_pkg::res_t           res0_q, res1_q, m_data_q;

  // Memory ports
  logic                    o_we, h_we, xy_we, wh_we;
  logic [IDX_W-1:0]        o_wa, o_ra, h_wa, g_ra;
  logic signed [8:0]       o_nb;
  logic [7:0]              o_wd, o_rd;
  logic [8:0]              h_wd, h_rd;
  logic [COORD_BITS-1:0]   x_rd, y_rd, nx, ny;
  logic [11:0]             w_rd, hh_rd;
  logic signed [15:0]      px16, py16;

  // Rectangle unit ports
  logic signed [COORD_BITS-1:0] rb_x, rb_y;
  logic signed [13:0]      ro_x0, ro_y0, ro_x1, ro_y1;
  logic signed [14:0]      rx0, ry0, rx1, ry1;
  logic [7:0]              rect_from;
  lzm_pkg::res_t           rect_base, rect_res;

  // Set-height planning
  logic signed [8:0]       old_h;
  logic signed [10:0]      req, lim11, ht11;
  logic signed [8:0]       sh_ht, sh_cur, sh_lim, sh_top;
  logic                    sh_up, sh_place, sh_lower, sh_hide, sh_go;
  logic [IDX_W-1:0]        s_idx, scan_idx;
  logic                    s_ok;

  // Load step decisions and output handoff
  lzm_pkg::res_t           load_res;
  state_e                  load_state;
  logic                    load_shift;
  logic                    emit_go;

  assign s_idx    = s_axis_tdata[IDX_W-1:0];
  assign scan_idx = cur_q[IDX_W-1:0];
  assign s_ok     = ({1'b0, s_axis_tdata[7:0]} < 9'(MAX_LAYERS)) && used_q[s_idx];
  assign emit_go  = (state_q == S_EMIT) && (!m_valid_q || m_axis_tready);

  // New origin wrapped to the coordinate width
  assign px16 = 16'(px_q);
  assign py16 = 16'(py_q);
  assign nx   = px16[COORD_BITS-1:0];
  assign ny   = py16[COORD_BITS-1:0];

  lzm_ram #(.DEPTH(MAX_LAYERS), .WIDTH(8)) u_order (
    .clk_i, .we_i(o_we), .waddr_i(o_wa), .wdata_i(o_wd), .raddr_i(o_ra), .rdata_o(o_rd)
  );
  lzm_ram #(.DEPTH(MAX_LAYERS), .WIDTH(9)) u_height (
    .clk_i, .we_i(h_we), .waddr_i(h_wa), .wdata_i(h_wd), .raddr_i(g_ra), .rdata_o(h_rd)
  );
  lzm_ram #(.DEPTH(MAX_LAYERS), .WIDTH(COORD_BITS)) u_pos_x (
    .clk_i, .we_i(xy_we), .waddr_i(lid_q[IDX_W-1:0]), .wdata_i(nx), .raddr_i(g_ra),
    .rdata_o(x_rd)
  );
  lzm_ram #(.DEPTH(MAX_LAYERS), .WIDTH(COORD_BITS)) u_pos_y (
    .clk_i, .we_i(xy_we), .waddr_i(lid_q[IDX_W-1:0]), .wdata_i(ny), .raddr_i(g_ra),
    .rdata_o(y_rd)
  );
  lzm_ram #(.DEPTH(MAX_LAYERS), .WIDTH(12)) u_size_w (
    .clk_i, .we_i(wh_we), .waddr_i(lid_q[IDX_W-1:0]), .wdata_i(sw_q), .raddr_i(g_ra),
    .rdata_o(w_rd)
  );
  lzm_ram #(.DEPTH(MAX_LAYERS), .WIDTH(12)) u_size_h (
    .clk_i, .we_i(wh_we), .waddr_i(lid_q[IDX_W-1:0]), .wdata_i(sh_q), .raddr_i(g_ra),
    .rdata_o(hh_rd)
  );

  // Memory addressing and writes
  always_comb begin
    g_ra  = (state_q == S_IDLE) ? s_idx : lid_q[IDX_W-1:0];
    o_nb  = up_q ? cur_q + 9'sd1 : cur_q - 9'sd1;
    o_ra  = o_nb[IDX_W-1:0];
    o_we  = 1'b0;
    o_wa  = cur_q[IDX_W-1:0];
    o_wd  = o_rd;
    h_we  = 1'b0;
    h_wa  = o_rd[IDX_W-1:0];
    h_wd  = cur_q;
    xy_we = (state_q == S_LOAD) && ok_q && (op_q == lzm_pkg::OP_MOVE);
    wh_we = (state_q == S_LOAD) && ok_q && (op_q == lzm_pkg::OP_SIZE);
    if (state_q == S_SCAN && !used_q[scan_idx]) begin
      h_we = 1'b1;
      h_wa = scan_idx;
      h_wd = 9'h1ff;
    end else if (state_q == S_SH_WR) begin
      o_we = 1'b1;
      h_we = 1'b1;
    end else if (state_q == S_PLACE) begin
      o_we = place_q;
      o_wa = ht_q[IDX_W-1:0];
      o_wd = lid_q;
      h_we = 1'b1;
      h_wa = lid_q[IDX_W-1:0];
      h_wd = ht_q;
    end
  end

  // Feed the shared rectangle unit
  always_comb begin
    rb_x  = gx_q;
    rb_y  = gy_q;
    ro_x0 = '0;
    ro_y0 = '0;
    ro_x1 = signed'({2'b00, gw_q});
    ro_y1 = signed'({2'b00, gh_q});
    if (state_q == S_LOAD) begin
      rb_x = x_rd;
      rb_y = y_rd;
      if (op_q == lzm_pkg::OP_REFRESH) begin
        ro_x0 = bx0_q;
        ro_y0 = by0_q;
        ro_x1 = bx1_q;
        ro_y1 = by1_q;
      end else begin
        ro_x1 = signed'({2'b00, w_rd});
        ro_y1 = signed'({2'b00, hh_rd});
      end
    end else if (state_q == S_MOVE2) begin
      rb_x = nx;
      rb_y = ny;
    end
  end

  lzm_rect #(.COORD_BITS(COORD_BITS)) u_rect (
    .base_x_i(rb_x), .base_y_i(rb_y),
    .off_x0_i(ro_x0), .off_y0_i(ro_y0), .off_x1_i(ro_x1), .off_y1_i(ro_y1),
    .x0_o(rx0), .y0_o(ry0), .x1_o(rx1), .y1_o(ry1)
  );

  // Pick the starting height for the redraw built this cycle
  always_comb begin
    unique case (state_q)
      S_LOAD:  rect_from = (op_q == lzm_pkg::OP_REFRESH) ? old_h[7:0] : 8'd0;
      S_PLACE: rect_from = lower_q ? ht_q[7:0] + 8'd1 : (hide_q ? 8'd0 : ht_q[7:0]);
      S_MOVE2: rect_from = hold_q[7:0];
      default: rect_from = 8'd0;
    endcase
  end

  always_comb begin
    rect_base             = '0;
    rect_base.kind        = lzm_pkg::KIND_REDRAW;
    rect_base.layer       = lid_q;
    rect_base.x0          = rx0;
    rect_base.y0          = ry0;
    rect_base.x1          = rx1;
    rect_base.y1          = ry1;
    rect_res              = rect_base;
    rect_res.from_height  = rect_from;
  end

  // Plan a height change: clamp, then pick shift direction and range
  always_comb begin
    old_h    = signed'(h_rd);
    req      = (op_q == lzm_pkg::OP_FREE) ? -11'sd1 : 11'(nh_q);
    lim11    = (old_h >= 0) ? 11'(top_q) : 11'(top_q) + 11'sd1;
    ht11     = (req > lim11) ? lim11 : req;
    if (ht11 < -11'sd1) ht11 = -11'sd1;
    sh_ht    = ht11[8:0];
    sh_lower = (old_h > sh_ht) && (sh_ht >= 0);
    sh_hide  = sh_ht < 0;
    sh_top   = top_q;
    sh_cur   = old_h;
    sh_lim   = sh_ht;
    sh_up    = 1'b0;
    sh_place = 1'b1;
    if (old_h > sh_ht) begin
      if (sh_hide) begin
        sh_lim   = top_q;
        sh_up    = 1'b1;
        sh_place = 1'b0;
        sh_top   = top_q - 9'sd1;
      end
    end else if (old_h >= 0) begin
      sh_up = 1'b1;
    end else begin
      sh_cur = top_q + 9'sd1;
      sh_top = top_q + 9'sd1;
    end
    sh_go = up_q ? (cur_q < lim_q) : (cur_q > lim_q);
  end

  // Decide the first result and next step of a loaded command
  always_comb begin
    load_res   = lzm_pkg::mk_plain(lzm_pkg::KIND_ACK, lid_q);
    load_state = S_EMIT;
    load_shift = 1'b0;
    if (ok_q) begin
      case (op_q) inside
        lzm_pkg::OP_FREE, lzm_pkg::OP_HEIGHT: begin
          if (sh_ht != old_h) begin
            load_shift = 1'b1;
            load_state = S_SH_RD;
          end
        end
        lzm_pkg::OP_MOVE: begin
          if (old_h >= 0) begin
            load_res   = rect_res;
            load_state = S_MOVE2;
          end
        end
        lzm_pkg::OP_REFRESH: begin
          if (old_h >= 0) load_res = rect_res;
        end
        default: ;
      endcase
    end
  end

  // Sequencer, pool state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      top_q     <= -9'sd1;
      m_valid_q <= 1'b0;
      sel_q     <= 1'b0;
    end else begin
      if (emit_go) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q  <= s_axis_tuser;
            lid_q <= s_axis_tdata[7:0];
            nh_q  <= s_axis_tdata[17:8];
            px_q  <= s_axis_tdata[31:18];
            py_q  <= s_axis_tdata[45:32];
            sw_q  <= s_axis_tdata[57:46];
            sh_q  <= s_axis_tdata[69:58];
            bx0_q <= s_axis_tdata[83:70];
            by0_q <= s_axis_tdata[97:84];
            bx1_q <= s_axis_tdata[111:98];
            by1_q <= s_axis_tdata[125:112];
            ok_q  <= s_ok;
            cur_q <= '0;
            sel_q <= 1'b0;
            two_q <= 1'b0;
            state_q <= (s_axis_tuser == lzm_pkg::OP_ALLOC) ? S_SCAN : S_LOAD;
          end
        end
        S_SCAN: begin
          // Advance to the first free layer
          if (!used_q[scan_idx]) begin
            used_q[scan_idx] <= 1'b1;
            res0_q  <= lzm_pkg::mk_plain(lzm_pkg::KIND_ALLOC, 8'(scan_idx));
            state_q <= S_EMIT;
          end else if (32'(scan_idx) == MAX_LAYERS - 1) begin
            res0_q  <= lzm_pkg::mk_plain(lzm_pkg::KIND_ALLOC_FAIL, 8'd0);
            state_q <= S_EMIT;
          end else begin
            cur_q <= cur_q + 9'sd1;
          end
        end
        S_LOAD: begin
          gx_q    <= x_rd;
          gy_q    <= y_rd;
          gw_q    <= w_rd;
          gh_q    <= hh_rd;
          hold_q  <= old_h;
          ht_q    <= sh_ht;
          res0_q  <= load_res;
          state_q <= load_state;
          if (ok_q && op_q == lzm_pkg::OP_FREE) used_q[lid_q[IDX_W-1:0]] <= 1'b0;
          if (load_shift) begin
            cur_q   <= sh_cur;
            lim_q   <= sh_lim;
            up_q    <= sh_up;
            place_q <= sh_place;
            lower_q <= sh_lower;
            hide_q  <= sh_hide;
            top_q   <= sh_top;
          end
        end
        S_SH_RD: state_q <= sh_go ? S_SH_WR : S_PLACE;
        S_SH_WR: begin
          cur_q   <= up_q ? cur_q + 9'sd1 : cur_q - 9'sd1;
          state_q <= S_SH_RD;
        end
        S_PLACE: begin
          res0_q  <= rect_res;
          res1_q  <= rect_base;
          two_q   <= lower_q;
          state_q <= S_EMIT;
        end
        S_MOVE2: begin
          res1_q  <= rect_res;
          two_q   <= 1'b1;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          // Hand a result to the output register once it is free
          if (emit_go) begin
            m_data_q  <= sel_q ? res1_q : res0_q;
            m_last_q  <= (sel_q == two_q);
            if (sel_q == two_q) state_q <= S_IDLE;
            else sel_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_data_q.kind;
  assign m_axis_tdata  = {4'b0000, m_data_q.from_height, m_data_q.y1, m_data_q.x1,
                          m_data_q.y0, m_data_q.x0, m_data_q.layer};

endmodule
`default_nettype wire

@@ sv/lzm_checker.sv @@
`default_nettype none
`include "layer_zorder_manager_core_defines.svh"
module lzm_checker (
  input wire         clk_i,
  input wire         rst_ni,
  input wire         s_axis_tvalid,
  input wire         s_axis_tready,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [79:0]  m_axis_tdata,
  input wire [1:0]   m_axis_tuser,
  input wire         m_axis_tlast
);

  // Reset drops any pending result
  `LZM_ASSERT_ALWAYS(a_rst_no_out, (!rst_ni |-> !m_axis_tvalid), "result valid in reset")
  // A command keeps the block busy for at least the next cycle
  `LZM_ASSERT(a_busy_after_cmd, (s_axis_tvalid && s_axis_tready |=> !s_axis_tready), "ready after transfer")
  // Stalled result holds
  `LZM_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")
  // Only redraw results can be followed by another result of the same command
  `LZM_ASSERT(a_single_last, (m_axis_tvalid && m_axis_tuser != lzm_pkg::KIND_REDRAW |-> m_axis_tlast), "non-redraw result without tlast")

endmodule

bind layer_zorder_manager_core lzm_checker u_lzm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

@@ bench/tb_layer_zorder_manager_core.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_layer_zorder_manager_core;

  localparam int NumItems  = 1800;
  localparam int CycleCap  = 4000000;
  localparam int HoldCycles = 600;

  // Operation codes with no defined function
  localparam logic [2:0] OpSpareLo = 3'd6;
  localparam logic [2:0] OpSpareHi = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  id;
    logic [9:0]  nh;
    logic [13:0] px, py;
    logic [11:0] w, h;
    logic [13:0] bx0, by0, bx1, by1;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         layer;
    logic signed [14:0] x0, y0, x1, y1;
    logic [7:0]         from_h;
    logic               last;
  } res_exp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  layer_zorder_manager_core dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the layer pool
  logic [7:0] zo_slot[256];
  int         zo_height[256];
  bit         zo_used[256];
  int         zo_top;
  int         geo_x[256], geo_y[256], geo_w[256], geo_h[256];
  bit         pos_set[256], size_set[256];
  logic [7:0] used_q[$];

  cmd_t       cmd_q[$];
  res_exp_t   redraw_q[$];
  res_exp_t   step_res[$];

  int  errors = 0;
  int  acc_cnt = 0;
  int  cycles = 0;
  bit  gen_done = 1'b0;

  function automatic logic signed [14:0] clip15(input longint v);
    if (v < -16384) return -15'sd16384;
    if (v > 16383) return 15'sd16383;
    return v[14:0];
  endfunction

  function automatic void emit(input logic [1:0] kind, input logic [7:0] layer,
                               input longint x0, input longint y0,
                               input longint x1, input longint y1, input int from_h);
    res_exp_t r;
    r.kind = kind;
    r.layer = layer;
    r.x0 = clip15(x0);
    r.y0 = clip15(y0);
    r.x1 = clip15(x1);
    r.y1 = clip15(y1);
    r.from_h = from_h[7:0];
    r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void emit_layer(input int id, input int from_h);
    emit(lzm_pkg::KIND_REDRAW, id[7:0], geo_x[id], geo_y[id],
         longint'(geo_x[id]) + geo_w[id], longint'(geo_y[id]) + geo_h[id], from_h);
  endfunction

  function automatic void put_slot(input int hgt, input logic [7:0] id);
    zo_slot[hgt & 255] = id;
    zo_height[id] = hgt;
  endfunction

  // Clamp the request, then shift the order table around the layer
  function automatic void restack(input int id, input int req);
    int prev, lim, tgt, k;
    prev = zo_height[id];
    lim = (prev >= 0) ? zo_top : zo_top + 1;
    tgt = (req > lim) ? lim : req;
    if (tgt < -1) tgt = -1;
    zo_height[id] = tgt;
    if (prev > tgt) begin
      if (tgt >= 0) begin
        for (k = prev; k > tgt; k--) put_slot(k, zo_slot[(k - 1) & 255]);
        put_slot(tgt, id[7:0]);
        emit_layer(id, tgt + 1);
      end else begin
        for (k = prev; k < zo_top; k++) put_slot(k, zo_slot[(k + 1) & 255]);
        zo_top--;
      end
      emit_layer(id, 0);
    end else if (prev < tgt) begin
      if (prev >= 0) begin
        for (k = prev; k < tgt; k++) put_slot(k, zo_slot[(k + 1) & 255]);
      end else begin
        for (k = zo_top; k >= tgt; k--) put_slot(k + 1, zo_slot[k & 255]);
        zo_top++;
      end
      put_slot(tgt, id[7:0]);
      emit_layer(id, tgt);
    end
  endfunction

  // Apply one command to the shadow pool and queue its results
  function automatic void predict_cmd(input cmd_t c);
    int id, k;
    bit found;
    id = c.id;
    step_res.delete();
    if (c.op == lzm_pkg::OP_ALLOC) begin
      found = 1'b0;
      for (k = 0; k < 256 && !found; k++) begin
        if (!zo_used[k]) begin
          found = 1'b1;
          zo_used[k] = 1'b1;
          zo_height[k] = -1;
          used_q.push_back(k[7:0]);
          emit(lzm_pkg::KIND_ALLOC, k[7:0], 0, 0, 0, 0, 0);
        end
      end
      if (!found) emit(lzm_pkg::KIND_ALLOC_FAIL, 8'd0, 0, 0, 0, 0, 0);
    end else if (zo_used[id]) begin
      case (c.op)
        lzm_pkg::OP_FREE: begin
          if (zo_height[id] >= 0) restack(id, -1);
          zo_used[id] = 1'b0;
          for (k = 0; k < used_q.size(); k++)
            if (used_q[k] == c.id) begin
              used_q.delete(k);
              break;
            end
        end
        lzm_pkg::OP_SIZE: begin
          geo_w[id] = c.w;
          geo_h[id] = c.h;
          size_set[id] = 1'b1;
        end
        lzm_pkg::OP_MOVE: begin
          if (zo_height[id] >= 0) emit_layer(id, 0);
          geo_x[id] = $signed(c.px);
          geo_y[id] = $signed(c.py);
          pos_set[id] = 1'b1;
          if (zo_height[id] >= 0) emit_layer(id, zo_height[id]);
        end
        lzm_pkg::OP_HEIGHT: restack(id, $signed(c.nh));
        lzm_pkg::OP_REFRESH: begin
          if (zo_height[id] >= 0)
            emit(lzm_pkg::KIND_REDRAW, c.id, longint'(geo_x[id]) + $signed(c.bx0),
                 longint'(geo_y[id]) + $signed(c.by0), longint'(geo_x[id]) + $signed(c.bx1),
                 longint'(geo_y[id]) + $signed(c.by1), zo_height[id]);
        end
        default: ;
      endcase
    end
    if (step_res.size() == 0) emit(lzm_pkg::KIND_ACK, c.id, 0, 0, 0, 0, 0);
    step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) redraw_q.push_back(step_res[i]);
  endfunction

  function automatic cmd_t noise_cmd(input logic [2:0] op, input logic [7:0] id);
    cmd_t c;
    c.op = op;
    c.id = id;
    c.nh = 10'($urandom);
    c.px = 14'($urandom);
    c.py = 14'($urandom);
    c.w = 12'($urandom);
    c.h = 12'($urandom);
    c.bx0 = 14'($urandom_range(0, 8192) - 4096);
    c.by0 = 14'($urandom_range(0, 8192) - 4096);
    c.bx1 = 14'($urandom_range(0, 8192) - 4096);
    c.by1 = 14'($urandom_range(0, 8192) - 4096);
    return c;
  endfunction

  // Keep geometry reads away from layers never sized or placed
  function automatic void send(input cmd_t c);
    int id;
    id = c.id;
    if (zo_used[id] && (c.op == lzm_pkg::OP_HEIGHT || c.op == lzm_pkg::OP_REFRESH) &&
        !(pos_set[id] && size_set[id]))
      c.op = size_set[id] ? lzm_pkg::OP_MOVE : lzm_pkg::OP_SIZE;
    predict_cmd(c);
    cmd_q.push_back(c);
  endfunction

  function automatic logic [7:0] pick_layer();
    if (used_q.size() == 0 || $urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return used_q[$urandom_range(0, used_q.size() - 1)];
  endfunction

  // Fill the command queue: directed part, then random traffic
  initial begin
    cmd_t c;
    int n, r, k;
    logic [2:0] op;
    foreach (zo_used[i]) begin
      zo_used[i] = 0;
      zo_height[i] = -1;
      zo_slot[i] = 0;
      pos_set[i] = 0;
      size_set[i] = 0;
    end
    zo_top = -1;

    // Directed: three layers, extreme geometry, every op and corner
    c = noise_cmd(lzm_pkg::OP_FREE, 8'd0);     send(c);  // unused layer
    for (k = 0; k < 3; k++) begin
      c = noise_cmd(lzm_pkg::OP_ALLOC, 8'hff); send(c);
    end
    c = noise_cmd(lzm_pkg::OP_SIZE, 8'd0); c.w = 12'd4095; c.h = 12'd4095; send(c);
    c = noise_cmd(lzm_pkg::OP_MOVE, 8'd0); c.px = 14'h1fff; c.py = 14'h1fff; send(c);
    c = noise_cmd(lzm_pkg::OP_SIZE, 8'd1); c.w = 12'd0; c.h = 12'd0; send(c);
    c = noise_cmd(lzm_pkg::OP_MOVE, 8'd1); c.px = 14'h2000; c.py = 14'h2000; send(c);
    c = noise_cmd(lzm_pkg::OP_SIZE, 8'd2); send(c);
    c = noise_cmd(lzm_pkg::OP_MOVE, 8'd2); send(c);
    c = noise_cmd(lzm_pkg::OP_HEIGHT, 8'd0); c.nh = 10'h1ff; send(c);  // clamp high, hidden
    c = noise_cmd(lzm_pkg::OP_HEIGHT, 8'd1); c.nh = 10'h1ff; send(c);
    c = noise_cmd(lzm_pkg::OP_HEIGHT, 8'd2); c.nh = 10'h1ff; send(c);
    c = noise_cmd(lzm_pkg::OP_HEIGHT, 8'd2); c.nh = 10'd0; send(c);    // lower to visible
    c = noise_cmd(lzm_pkg::OP_HEIGHT, 8'd2); c.nh = 10'h1ff; send(c);  // clamp high, visible
    c = noise_cmd(lzm_pkg::OP_HEIGHT, 8'd2); c.nh = 10'd2; send(c);    // unchanged
    c = noise_cmd(lzm_pkg::OP_REFRESH, 8'd0); c.bx0 = -14'sd4096; c.by0 = -14'sd4096;
    c.bx1 = 14'sd4096; c.by1 = 14'sd4096; send(c);
    c = noise_cmd(lzm_pkg::OP_MOVE, 8'd1); c.px = 14'h1fff; c.py = 14'h2000; send(c);
    c = noise_cmd(lzm_pkg::OP_HEIGHT, 8'd1); c.nh = 10'h200; send(c);  // clamp low, hide
    c = noise_cmd(lzm_pkg::OP_REFRESH, 8'd1); send(c);                  // hidden refresh
    c = noise_cmd(OpSpareLo, 8'd0); send(c);
    c = noise_cmd(OpSpareHi, 8'd255); send(c);
    c = noise_cmd(lzm_pkg::OP_FREE, 8'd0); send(c);                     // free visible
    c = noise_cmd(lzm_pkg::OP_SIZE, 8'd255); send(c);

    // Random traffic, with one pass that fills the pool and then frees most of it
    n = 0;
    while (n < NumItems) begin
      if (n == 700) begin
        while (used_q.size() < 256) begin
          c = noise_cmd(lzm_pkg::OP_ALLOC, 8'($urandom)); send(c); n++;
        end
        c = noise_cmd(lzm_pkg::OP_ALLOC, 8'($urandom)); send(c); n++;
        for (k = 0; k < 220; k++) begin
          c = noise_cmd(lzm_pkg::OP_FREE, used_q[$urandom_range(0, used_q.size() - 1)]);
          send(c); n++;
        end
      end
      r = $urandom_range(0, 99);
      if (r < 12) op = lzm_pkg::OP_ALLOC;
      else if (r < 20) op = lzm_pkg::OP_FREE;
      else if (r < 33) op = lzm_pkg::OP_SIZE;
      else if (r < 46) op = lzm_pkg::OP_MOVE;
      else if (r < 83) op = lzm_pkg::OP_HEIGHT;
      else if (r < 97) op = lzm_pkg::OP_REFRESH;
      else op = ($urandom_range(0, 1) == 0) ? OpSpareLo : OpSpareHi;
      c = noise_cmd(op, pick_layer());
      r = $urandom_range(0, 19);
      if (r < 14) c.nh = 10'($urandom_range(0, zo_top + 2) - 1);
      else if (r < 17) c.nh = 10'h3ff;
      send(c);
      n++;
    end
    gen_done = 1'b1;
  end

  // Reset once at the start
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int idle_phase();
    return (acc_cnt * 3) / (cmd_q.size() + acc_cnt + 1);
  endfunction

  // Offer queued commands, idling at random between transfers
  always @(posedge clk_i) begin
    cmd_t c;
    int ph;
    bit took, idle;
    took = s_axis_tvalid && s_axis_tready;
    if (took) acc_cnt <= acc_cnt + 1;
    ph = idle_phase();
    idle = (ph == 0) ? ($urandom_range(0, 99) < 14) :
           (ph == 1) ? ($urandom_range(0, 99) < 59) : 1'b0;
    if (rst_ni && (took || !s_axis_tvalid)) begin
      if (gen_done && cmd_q.size() > 0 && !idle) begin
        c = cmd_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c.op;
        s_axis_tdata <= {2'b00, c.by1, c.bx1, c.by0, c.bx0, c.h, c.w, c.py, c.px, c.nh, c.id};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stalls, plus one long hold-off to back up the block
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk_i) begin
    int ph;
    ph = idle_phase();
    if (!hold_done && acc_cnt >= 1400) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (ph == 0) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 59);
    end else if (ph == 1) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 14);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    res_exp_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.layer = m_axis_tdata[7:0];
      got.x0 = m_axis_tdata[22:8];
      got.y0 = m_axis_tdata[37:23];
      got.x1 = m_axis_tdata[52:38];
      got.y1 = m_axis_tdata[67:53];
      got.from_h = m_axis_tdata[75:68];
      got.last = m_axis_tlast;
      if (redraw_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", got);
      end else begin
        want = redraw_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Cycle cap
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("status: fail");
      $finish;
    end
  end

  // Wait for drain, then settle and report
  initial begin
    wait (gen_done);
    @(posedge clk_i);
    while (cmd_q.size() > 0 || s_axis_tvalid || redraw_q.size() > 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (errors == 0 && redraw_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
